FILE: rtl/dks_pkg.sv
// Package for the DES key schedule: sizes, permutation tables,
// the stage payload types and the bit-routing functions.
// No dependencies.
package dks_pkg;

	localparam int KeyBits  = 64;
	localparam int CdBits   = 56;
	localparam int HalfBits = 28;
	localparam int SubBits  = 48;
	localparam int Rounds   = 16;
	localparam int RndBits  = $clog2(Rounds);

	typedef logic [HalfBits-1:0] half_t;
	typedef logic [RndBits-1:0]  rnd_t;
	typedef logic [4:0]          shamt_t;

	localparam logic [6:0] Pc1Tab [CdBits] = '{
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
		7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
		7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
		7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
		7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
	};

	localparam logic [5:0] Pc2Tab [SubBits] = '{
		6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
		6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
		6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
		6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
	};

	// total left rotation of C0/D0 after each round, modulo 28
	localparam shamt_t CumShift [Rounds] = '{
		5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
		5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd0
	};

	// seed of one round: which round, last of run, unrotated halves
	typedef struct packed {
		rnd_t  rnd;
		logic  last;
		half_t c;
		half_t d;
	} seed_t;

	// rotated halves for one round
	typedef struct packed {
		rnd_t  rnd;
		logic  last;
		half_t c;
		half_t d;
	} rot_t;

	function automatic logic [CdBits-1:0] pc1(input logic [KeyBits-1:0] k);
		logic [CdBits-1:0] r;
		r = '0;
		for (int i = 0; i < CdBits; i++) begin
			r[CdBits-1-i] = k[6'(KeyBits - int'(Pc1Tab[i]))];
		end
		return r;
	endfunction

	function automatic logic [SubBits-1:0] pc2(input logic [CdBits-1:0] cd);
		logic [SubBits-1:0] r;
		r = '0;
		for (int i = 0; i < SubBits; i++) begin
			r[SubBits-1-i] = cd[6'(CdBits - int'(Pc2Tab[i]))];
		end
		return r;
	endfunction

	function automatic half_t rotl28(input half_t v, input shamt_t n);
		logic [2*HalfBits-1:0] t;
		t = {v, v} << n;
		return t[2*HalfBits-1:HalfBits];
	endfunction

endpackage

FILE: rtl/dks_key_if.sv
// Key input channel: valid/ready handshake with the 64-bit key.
// Depends on dks_pkg.
interface dks_key_if;
	logic                       valid;
	logic                       ready;
	logic [dks_pkg::KeyBits-1:0] key;
	modport source (output valid, output key, input ready);
	modport sink   (input valid, input key, output ready);
endinterface

FILE: rtl/dks_sub_if.sv
// Subkey output channel: valid/ready handshake with round, subkey, last.
// Depends on dks_pkg.
interface dks_sub_if;
	logic                        valid;
	logic                        ready;
	logic [4:0]                  round_index;
	logic [dks_pkg::SubBits-1:0] subkey;
	logic                        last;
	modport source (output valid, output round_index, output subkey, output last, input ready);
	modport sink   (input valid, input round_index, input subkey, input last, output ready);
endinterface

FILE: rtl/dks_cfg_if.sv
// Configuration write channel carrying the key_order register.
// No dependencies.
interface dks_cfg_if;
	logic valid;
	logic ready;
	logic key_order;
	modport source (output valid, output key_order, input ready);
	modport sink   (input valid, input key_order, output ready);
endinterface

FILE: rtl/des_key_schedule.sv
// DES key schedule top level: key_order register and three pipeline
// stages (PC-1 plus round counter, rotate, PC-2). Depends on dks_pkg,
// dks_key_if, dks_sub_if, dks_cfg_if, dks_sched, dks_rot, dks_pc2.
//
//   channel  dir  handshake     payload
//   key_ch   in   valid/ready   key[63:0]
//   cfg      in   valid/ready   key_order
//   sub      out  valid/ready   round_index[4:0], subkey[47:0], last
//
// One key yields sixteen subkeys, one per cycle when sub is ready; a
// new key is taken as the stage 1 round counter issues its last seed.
// An accepted key's first subkey then passes the stage 2 and 3 registers.
// Reset clears valid bits, the round counter and key_order (encrypt order).
// A stall on sub holds every stage; nothing is dropped or repeated.
module des_key_schedule (
	input  logic      clk,
	input  logic      arst_n,
	dks_key_if.sink   key_ch,
	dks_cfg_if.sink   cfg,
	dks_sub_if.source sub
);

	logic           key_order_q;
	logic           seed_valid;
	logic           seed_ready;
	dks_pkg::seed_t seed;
	logic           rot_valid;
	logic           rot_ready;
	dks_pkg::rot_t  rot;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_order_q <= 1'b0;
		end else if (cfg.valid) begin
			key_order_q <= cfg.key_order;
		end
	end

	dks_sched u_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_order (key_order_q),
		.in_valid  (key_ch.valid),
		.in_ready  (key_ch.ready),
		.key       (key_ch.key),
		.out_valid (seed_valid),
		.out_ready (seed_ready),
		.out_seed  (seed)
	);

	dks_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seed_valid),
		.in_ready  (seed_ready),
		.in_seed   (seed),
		.out_valid (rot_valid),
		.out_ready (rot_ready),
		.out_rot   (rot)
	);

	dks_pc2 u_pc2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rot_valid),
		.in_ready (rot_ready),
		.in_rot   (rot),
		.sub      (sub)
	);

endmodule

FILE: rtl/dks_sched.sv
// Stage 1: PC-1 register holding C0/D0 and the round counter that
// issues sixteen round seeds per key. Depends on dks_pkg.
module dks_sched (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           key_order,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [63:0]    key,
	output logic           out_valid,
	input  logic           out_ready,
	output dks_pkg::seed_t out_seed
);

	logic                  valid_s1;
	dks_pkg::half_t        c_s1;
	dks_pkg::half_t        d_s1;
	dks_pkg::rnd_t         cnt_q;
	logic [dks_pkg::CdBits-1:0] kp;
	logic                  fire;
	logic                  done;

	assign kp       = dks_pkg::pc1(key);
	assign fire     = valid_s1 && out_ready;
	assign done     = fire && (cnt_q == dks_pkg::rnd_t'(dks_pkg::Rounds - 1));
	assign in_ready = !valid_s1 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			c_s1 <= kp[dks_pkg::CdBits-1:dks_pkg::HalfBits];
			d_s1 <= kp[dks_pkg::HalfBits-1:0];
		end
	end

	always_comb begin
		out_valid     = valid_s1;
		out_seed.rnd  = key_order ? dks_pkg::rnd_t'(dks_pkg::Rounds - 1) - cnt_q : cnt_q;
		out_seed.last = (cnt_q == dks_pkg::rnd_t'(dks_pkg::Rounds - 1));
		out_seed.c    = c_s1;
		out_seed.d    = d_s1;
	end

endmodule

FILE: rtl/dks_rot.sv
// Stage 2: rotates C0/D0 by the cumulative shift of the round.
// Depends on dks_pkg.
module dks_rot (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dks_pkg::seed_t in_seed,
	output logic           out_valid,
	input  logic           out_ready,
	output dks_pkg::rot_t  out_rot
);

	logic            valid_s2;
	dks_pkg::rot_t   rot_s2;
	dks_pkg::shamt_t sh;

	assign sh       = dks_pkg::CumShift[in_seed.rnd];
	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rot_s2.rnd  <= in_seed.rnd;
			rot_s2.last <= in_seed.last;
			rot_s2.c    <= dks_pkg::rotl28(in_seed.c, sh);
			rot_s2.d    <= dks_pkg::rotl28(in_seed.d, sh);
		end
	end

	assign out_valid = valid_s2;
	assign out_rot   = rot_s2;

endmodule

FILE: rtl/dks_pc2.sv
// Stage 3: PC-2 of the rotated halves into the output register.
// Depends on dks_pkg and dks_sub_if.
module dks_pc2 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dks_pkg::rot_t in_rot,
	dks_sub_if.source     sub
);

	logic                        valid_s3;
	logic [4:0]                  round_s3;
	logic [dks_pkg::SubBits-1:0] subkey_s3;
	logic                        last_s3;

	assign in_ready = !valid_s3 || sub.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			round_s3  <= 5'(in_rot.rnd) + 5'd1;
			subkey_s3 <= dks_pkg::pc2({in_rot.c, in_rot.d});
			last_s3   <= in_rot.last;
		end
	end

	assign sub.valid       = valid_s3;
	assign sub.round_index = round_s3;
	assign sub.subkey      = subkey_s3;
	assign sub.last        = last_s3;

endmodule
